@@ rtl/prqs_pkg.sv @@
// Shared constants and defaults for the priority ready-queue scheduler.
`timescale 1ns / 1ps
package prqs_pkg;

   localparam int NUM_PROCS_DEFAULT = 64;
   localparam int PRIO_BITS_DEFAULT = 8;

   localparam int CMD_W    = 3;
   localparam int TGT_W    = 6;
   localparam int NPRIO_W  = 8;
   localparam int STATUS_W = 2;
   localparam int OID_W    = 6;
   localparam int LIFE_W   = 2;

   localparam logic [CMD_W-1:0] CMD_CREATE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_YIELD     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_BLOCK     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UNBLOCK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TERMINATE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_BLOCKED = 2'd3;

   localparam logic [LIFE_W-1:0] LS_FREE    = 2'd0;
   localparam logic [LIFE_W-1:0] LS_READY   = 2'd1;
   localparam logic [LIFE_W-1:0] LS_RUNNING = 2'd2;
   localparam logic [LIFE_W-1:0] LS_BLOCKED = 2'd3;

endpackage

@@ rtl/prqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module prqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/priority_ready_queue_scheduler.sv @@
// Top level: process table, sorted ready queue and command sequencer.
//
//  channel | direction | ports                                         | handshake
//  req     | in        | req_cmd, req_target_id, req_new_priority      | req_valid / req_ready
//  rsp     | out       | rsp_status, rsp_created_id, rsp_running_id,   | rsp_valid / rsp_ready
//          |           | rsp_switched, rsp_previous_id                 |
//
// The ready queue holds at most NUM_PROCS-1 entries. The queue RAM is walked one entry
// per cycle for each insert or removal, and a yield with a process running performs two
// such walks, an insert and a dispatch.
// Reset needs no clearing pass; unwritten table slots are told apart by the
// id counter. The result register holds a result until taken; the next command is
// accepted meanwhile and is only held back if its own result would overwrite it.
`timescale 1ns / 1ps
module priority_ready_queue_scheduler
   import prqs_pkg::*;
#(
   parameter int NUM_PROCS = NUM_PROCS_DEFAULT,
   parameter int PRIO_BITS = PRIO_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [TGT_W-1:0]    req_target_id,
   input  logic [NPRIO_W-1:0]  req_new_priority,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OID_W-1:0]    rsp_created_id,
   output logic [OID_W-1:0]    rsp_running_id,
   output logic                rsp_switched,
   output logic [OID_W-1:0]    rsp_previous_id
);

   localparam int ID_W  = $clog2(NUM_PROCS);
   localparam int CNT_W = $clog2(NUM_PROCS + 1);
   localparam int PRIO_W = PRIO_BITS;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } qent_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [LIFE_W-1:0] life;
   } tent_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_EVAL, S_ENQ_START, S_ENQ, S_ENQ_ZERO,
      S_REM_START, S_REM, S_DISP, S_DISP_FIN, S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [TGT_W-1:0]    tgt_ff, tgt_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [ID_W-1:0]     prev_ff, prev_in;
   logic [ID_W-1:0]     running_ff, running_in;
   logic [CNT_W-1:0]    counter_ff, counter_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic                one_wr_ff, one_wr_in;
   logic [ID_W-1:0]     look_ff, look_in;
   logic [ID_W-1:0]     enq_id_ff, enq_id_in;
   logic [PRIO_W-1:0]   enq_prio_ff, enq_prio_in;
   logic [ID_W-1:0]     i_ff, i_in;
   logic                found_ff, found_in;
   logic                head_ff, head_in;
   logic [ID_W-1:0]     rem_id_ff, rem_id_in;
   logic [PRIO_W-1:0]   rem_prio_ff, rem_prio_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     created_ff, created_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OID_W-1:0]    rsp_created_ff, rsp_created_in;
   logic [OID_W-1:0]    rsp_running_ff, rsp_running_in;
   logic                rsp_switched_ff, rsp_switched_in;
   logic [OID_W-1:0]    rsp_previous_ff, rsp_previous_in;

   logic                t_we;
   logic [ID_W-1:0]     t_waddr, t_raddr;
   tent_type            t_wdata, t_rdata, tent;
   logic                q_we;
   logic [ID_W-1:0]     q_waddr, q_raddr;
   qent_type            q_wdata, q_rdata;

   logic                rem_match, rem_last;
   state_type           after_enq, after_rem;

   prqs_ram #(.WIDTH(PRIO_W + LIFE_W), .DEPTH(NUM_PROCS)) u_table (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   prqs_ram #(.WIDTH(PRIO_W + ID_W), .DEPTH(NUM_PROCS)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // slots never handed out read as free; the idle slot reads as running until written
   always_comb begin
      tent = t_rdata;
      if (look_ff == '0 || CNT_W'(look_ff) >= counter_ff) begin
         tent = '{prio: '0, life: LS_FREE};
      end else if (look_ff == ID_W'(1) && !one_wr_ff) begin
         tent = '{prio: '0, life: LS_RUNNING};
      end
   end

   assign after_enq = (cmd_ff == CMD_YIELD) ? S_DISP : S_RESP;
   assign after_rem = (look_ff == running_ff) ? S_DISP : S_RESP;
   assign rem_match = head_ff ? (i_ff == '0) : (q_rdata.id == look_ff);
   assign rem_last  = (CNT_W'(i_ff) + CNT_W'(1)) == len_ff;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      tgt_in          = tgt_ff;
      prio_in         = prio_ff;
      prev_in         = prev_ff;
      running_in      = running_ff;
      counter_in      = counter_ff;
      len_in          = len_ff;
      one_wr_in       = one_wr_ff;
      look_in         = look_ff;
      enq_id_in       = enq_id_ff;
      enq_prio_in     = enq_prio_ff;
      i_in            = i_ff;
      found_in        = found_ff;
      head_in         = head_ff;
      rem_id_in       = rem_id_ff;
      rem_prio_in     = rem_prio_ff;
      status_in       = status_ff;
      created_in      = created_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_created_in  = rsp_created_ff;
      rsp_running_in  = rsp_running_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_previous_in = rsp_previous_ff;
      t_we    = 1'b0;
      t_waddr = '0;
      t_wdata = '0;
      t_raddr = '0;
      q_we    = 1'b0;
      q_waddr = '0;
      q_wdata = '0;
      q_raddr = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               tgt_in     = req_target_id;
               prio_in    = PRIO_W'(req_new_priority);
               prev_in    = running_ff;
               status_in  = ST_OK;
               created_in = '0;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            case (cmd_ff) inside
               CMD_CREATE: begin
                  if (counter_ff >= CNT_W'(NUM_PROCS)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     created_in  = ID_W'(counter_ff);
                     counter_in  = counter_ff + CNT_W'(1);
                     t_we        = 1'b1;
                     t_waddr     = ID_W'(counter_ff);
                     t_wdata     = '{prio: prio_ff, life: LS_READY};
                     enq_id_in   = ID_W'(counter_ff);
                     enq_prio_in = prio_ff;
                     state_in    = S_ENQ_START;
                  end
               end
               CMD_YIELD: begin
                  if (running_ff != '0) begin
                     t_raddr  = running_ff;
                     look_in  = running_ff;
                     state_in = S_EVAL;
                  end else begin
                     state_in = S_DISP;
                  end
               end
               CMD_BLOCK, CMD_UNBLOCK, CMD_TERMINATE: begin
                  if (tgt_ff == '0 || 32'(tgt_ff) >= NUM_PROCS) begin
                     status_in = ST_INVALID;
                     state_in  = S_RESP;
                  end else begin
                     t_raddr  = ID_W'(tgt_ff);
                     look_in  = ID_W'(tgt_ff);
                     state_in = S_EVAL;
                  end
               end
               default: begin
                  status_in = ST_INVALID;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_EVAL: begin
            if (cmd_ff == CMD_YIELD) begin
               t_we        = 1'b1;
               t_waddr     = look_ff;
               t_wdata     = '{prio: tent.prio, life: LS_READY};
               enq_id_in   = look_ff;
               enq_prio_in = tent.prio;
               state_in    = S_ENQ_START;
            end else if (tent.life == LS_FREE) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else begin
               case (cmd_ff)
                  CMD_UNBLOCK: begin
                     if (tent.life != LS_BLOCKED) begin
                        status_in = ST_NOT_BLOCKED;
                        state_in  = S_RESP;
                     end else begin
                        t_we        = 1'b1;
                        t_waddr     = look_ff;
                        t_wdata     = '{prio: tent.prio, life: LS_READY};
                        enq_id_in   = look_ff;
                        enq_prio_in = tent.prio;
                        state_in    = S_ENQ_START;
                     end
                  end
                  default: begin
                     t_we    = 1'b1;
                     t_waddr = look_ff;
                     if (cmd_ff == CMD_TERMINATE) begin
                        t_wdata = '{prio: '0, life: LS_FREE};
                     end else begin
                        t_wdata = '{prio: tent.prio, life: LS_BLOCKED};
                     end
                     if (tent.life == LS_READY) begin
                        state_in = S_REM_START;
                     end else begin
                        state_in = after_rem;
                     end
                  end
               endcase
            end
         end
         S_ENQ_START: begin
            if (len_ff == '0) begin
               q_we     = 1'b1;
               q_waddr  = '0;
               q_wdata  = '{prio: enq_prio_ff, id: enq_id_ff};
               len_in   = len_ff + CNT_W'(1);
               state_in = after_enq;
            end else begin
               q_raddr  = ID_W'(len_ff - CNT_W'(1));
               i_in     = ID_W'(len_ff - CNT_W'(1));
               state_in = S_ENQ;
            end
         end
         S_ENQ: begin
            q_we    = 1'b1;
            q_waddr = i_ff + ID_W'(1);
            if (q_rdata.prio >= enq_prio_ff) begin
               q_wdata  = '{prio: enq_prio_ff, id: enq_id_ff};
               len_in   = len_ff + CNT_W'(1);
               state_in = after_enq;
            end else begin
               q_wdata = q_rdata;
               if (i_ff == '0) begin
                  state_in = S_ENQ_ZERO;
               end else begin
                  i_in    = i_ff - ID_W'(1);
                  q_raddr = i_ff - ID_W'(1);
               end
            end
         end
         S_ENQ_ZERO: begin
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = '{prio: enq_prio_ff, id: enq_id_ff};
            len_in   = len_ff + CNT_W'(1);
            state_in = after_enq;
         end
         S_REM_START: begin
            head_in  = 1'b0;
            found_in = 1'b0;
            i_in     = '0;
            q_raddr  = '0;
            state_in = S_REM;
         end
         S_DISP: begin
            if (len_ff == '0) begin
               running_in = '0;
               state_in   = S_RESP;
            end else begin
               head_in  = 1'b1;
               found_in = 1'b0;
               i_in     = '0;
               q_raddr  = '0;
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (found_ff) begin
               q_we    = 1'b1;
               q_waddr = i_ff - ID_W'(1);
               q_wdata = q_rdata;
            end else if (rem_match) begin
               found_in    = 1'b1;
               rem_id_in   = q_rdata.id;
               rem_prio_in = q_rdata.prio;
            end
            if (rem_last) begin
               if (found_ff || rem_match) begin
                  len_in = len_ff - CNT_W'(1);
               end
               state_in = head_ff ? S_DISP_FIN : after_rem;
            end else begin
               i_in    = i_ff + ID_W'(1);
               q_raddr = i_ff + ID_W'(1);
            end
         end
         S_DISP_FIN: begin
            t_we       = 1'b1;
            t_waddr    = rem_id_ff;
            t_wdata    = '{prio: rem_prio_ff, life: LS_RUNNING};
            running_in = rem_id_ff;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_created_in  = OID_W'(created_ff);
               rsp_running_in  = OID_W'(running_ff);
               rsp_switched_in = running_ff != prev_ff;
               rsp_previous_in = OID_W'(prev_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (t_we && t_waddr == ID_W'(1)) begin
         one_wr_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= ID_W'(1);
         counter_ff   <= CNT_W'(2);
         len_ff       <= '0;
         one_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         counter_ff   <= counter_in;
         len_ff       <= len_in;
         one_wr_ff    <= one_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff          <= cmd_in;
      tgt_ff          <= tgt_in;
      prio_ff         <= prio_in;
      prev_ff         <= prev_in;
      look_ff         <= look_in;
      enq_id_ff       <= enq_id_in;
      enq_prio_ff     <= enq_prio_in;
      i_ff            <= i_in;
      found_ff        <= found_in;
      head_ff         <= head_in;
      rem_id_ff       <= rem_id_in;
      rem_prio_ff     <= rem_prio_in;
      status_ff       <= status_in;
      created_ff      <= created_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_created_ff  <= rsp_created_in;
      rsp_running_ff  <= rsp_running_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_previous_ff <= rsp_previous_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_created_id  = rsp_created_ff;
   assign rsp_running_id  = rsp_running_ff;
   assign rsp_switched    = rsp_switched_ff;
   assign rsp_previous_id = rsp_previous_ff;

endmodule

@@ rtl/prqs_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module prqs_checker
   import prqs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [CMD_W-1:0]    req_cmd,
   input logic [TGT_W-1:0]    req_target_id,
   input logic [NPRIO_W-1:0]  req_new_priority,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [OID_W-1:0]    rsp_created_id,
   input logic [OID_W-1:0]    rsp_running_id,
   input logic                rsp_switched,
   input logic [OID_W-1:0]    rsp_previous_id
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_running_id) && $stable(rsp_previous_id) && $stable(rsp_created_id))
      else $error("result changed while stalled");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while previous command in progress");

   a_no_switch_same_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_switched |-> rsp_running_id == rsp_previous_id)
      else $error("running id changed without switch flag");

   a_failure_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_created_id == '0 && !rsp_switched)
      else $error("failed command created or switched");

   a_create_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_created_id != '0 |-> rsp_status == ST_OK && !rsp_switched)
      else $error("create reported a dispatch or a failure");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (.*);

@@ tb/sched_sb_pkg.sv @@
// Scoreboard package for the scheduler testbench: result type, state predictor and checker.
`timescale 1ns / 1ps
package sched_sb_pkg;
   import prqs_pkg::*;

   localparam int NPROC = NUM_PROCS_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OID_W-1:0]    created;
      logic [OID_W-1:0]    running;
      logic                switched;
      logic [OID_W-1:0]    previous;
   } sched_result_type;

   class sched_scoreboard;
      logic [NPRIO_W-1:0] prio_tab [NPROC];
      logic [LIFE_W-1:0]  life [NPROC];
      int                 ready_q [$];
      int                 running;
      int                 next_id;
      sched_result_type   pending_results [$];
      int                 errors;
      int                 checked;
      int                 switches;
      int                 full_hits;
      int                 cmd_seen [8];

      function new();
         for (int i = 0; i < NPROC; i++) begin
            prio_tab[i] = '0;
            life[i]     = LS_FREE;
         end
         for (int i = 0; i < 8; i++) cmd_seen[i] = 0;
         life[1]   = LS_RUNNING;
         running   = 1;
         next_id   = 2;
         errors    = 0;
         checked   = 0;
         switches  = 0;
         full_hits = 0;
      endfunction

      // queue behind every entry of greater or equal priority
      function void make_ready(int id);
         int pos;
         pos = 0;
         while (pos < ready_q.size() && prio_tab[ready_q[pos]] >= prio_tab[id]) pos++;
         ready_q.insert(pos, id);
         life[id] = LS_READY;
      endfunction

      function void unqueue(int id);
         for (int i = 0; i < ready_q.size(); i++) begin
            if (ready_q[i] == id) begin
               ready_q.delete(i);
               return;
            end
         end
      endfunction

      function void dispatch();
         if (ready_q.size() == 0) begin
            running = 0;
            return;
         end
         running = ready_q.pop_front();
         life[running] = LS_RUNNING;
      endfunction

      function bit is_live(int id);
         return id != 0 && id < NPROC && life[id] != LS_FREE;
      endfunction

      function void predict_command(logic [CMD_W-1:0] cmd, logic [TGT_W-1:0] tgt,
                                    logic [NPRIO_W-1:0] prio);
         sched_result_type r;
         int               prev;
         int               t;
         r    = '0;
         prev = running;
         t    = int'(tgt);
         r.status = ST_OK;
         cmd_seen[cmd]++;
         case (cmd)
            CMD_CREATE: begin
               if (next_id >= NPROC) begin
                  r.status = ST_FULL;
                  full_hits++;
               end else begin
                  r.created = OID_W'(next_id);
                  prio_tab[next_id] = prio;
                  make_ready(next_id);
                  next_id++;
               end
            end
            CMD_YIELD: begin
               if (running != 0) make_ready(running);
               if (ready_q.size() != 0) dispatch();
            end
            CMD_BLOCK: begin
               if (!is_live(t)) begin
                  r.status = ST_INVALID;
               end else begin
                  if (life[t] == LS_READY) unqueue(t);
                  life[t] = LS_BLOCKED;
                  if (t == running) dispatch();
               end
            end
            CMD_UNBLOCK: begin
               if (!is_live(t)) r.status = ST_INVALID;
               else if (life[t] != LS_BLOCKED) r.status = ST_NOT_BLOCKED;
               else make_ready(t);
            end
            CMD_TERMINATE: begin
               if (!is_live(t)) begin
                  r.status = ST_INVALID;
               end else begin
                  if (life[t] == LS_READY) unqueue(t);
                  life[t]     = LS_FREE;
                  prio_tab[t] = '0;
                  if (t == running) dispatch();
               end
            end
            default: r.status = ST_INVALID;
         endcase
         r.running  = OID_W'(running);
         r.switched = (running != prev);
         r.previous = OID_W'(prev);
         if (r.switched) switches++;
         pending_results.push_back(r);
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function logic [TGT_W-1:0] pick_target(bit blocked_only);
         int cand [$];
         for (int i = 1; i < NPROC; i++)
            if (life[i] != LS_FREE && (!blocked_only || life[i] == LS_BLOCKED))
               cand.push_back(i);
         if (cand.size() == 0) return TGT_W'($urandom_range(0, NPROC - 1));
         return TGT_W'(cand[$urandom_range(0, cand.size() - 1)]);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_result(sched_result_type got);
         sched_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result %h with nothing outstanding", got));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.status !== want.status)
            report($sformatf("result %0d status %0d, want %0d", checked, got.status,
                             want.status));
         if (got.created !== want.created)
            report($sformatf("result %0d created_id %0d, want %0d", checked, got.created,
                             want.created));
         if (got.running !== want.running)
            report($sformatf("result %0d running_id %0d, want %0d", checked, got.running,
                             want.running));
         if (got.switched !== want.switched)
            report($sformatf("result %0d switched %0b, want %0b", checked, got.switched,
                             want.switched));
         if (got.previous !== want.previous)
            report($sformatf("result %0d previous_id %0d, want %0d", checked, got.previous,
                             want.previous));
      endtask
   endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench for the priority ready-queue scheduler.
`timescale 1ns / 1ps
module tb_top;
   import prqs_pkg::*;
   import sched_sb_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int RANDOM_ITEMS = 630;
   localparam int CALM_ITEMS   = 120;
   localparam int DRAIN_CYCLES = 300;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [TGT_W-1:0]    req_target_id;
   logic [NPRIO_W-1:0]  req_new_priority;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [OID_W-1:0]    rsp_created_id;
   logic [OID_W-1:0]    rsp_running_id;
   logic                rsp_switched;
   logic [OID_W-1:0]    rsp_previous_id;

   sched_scoreboard sb;
   bit              idling_on;
   int              cycle_count = 0;
   int              stall_left;

   priority_ready_queue_scheduler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_target_id    (req_target_id),
      .req_new_priority (req_new_priority),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_created_id   (rsp_created_id),
      .rsp_running_id   (rsp_running_id),
      .rsp_switched     (rsp_switched),
      .rsp_previous_id  (rsp_previous_id)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  sb.outstanding());
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_status, rsp_created_id, rsp_running_id, rsp_switched,
                           rsp_previous_id});
   end

   // stall the result channel in bursts
   initial begin
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_cmd(logic [CMD_W-1:0] c, logic [TGT_W-1:0] t, logic [NPRIO_W-1:0] p);
      int gap;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_cmd          <= c;
      req_target_id    <= t;
      req_new_priority <= p;
      do @(posedge clock); while (!req_ready);
      sb.predict_command(c, t, p);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic directed_cmds();
      send_cmd(CMD_YIELD, 6'd0, 8'd0);
      send_cmd(CMD_CREATE, 6'd0, 8'd255);
      send_cmd(CMD_CREATE, 6'd63, 8'd0);
      send_cmd(CMD_CREATE, 6'd0, 8'd255);
      send_cmd(CMD_YIELD, 6'd63, 8'd255);
      send_cmd(CMD_BLOCK, 6'd0, 8'd0);
      send_cmd(CMD_BLOCK, 6'd63, 8'd0);
      send_cmd(CMD_UNBLOCK, 6'd3, 8'd0);
      send_cmd(CMD_BLOCK, 6'd3, 8'd0);
      send_cmd(CMD_BLOCK, 6'd3, 8'd0);
      send_cmd(CMD_UNBLOCK, 6'd3, 8'd0);
      send_cmd(CMD_BLOCK, 6'd2, 8'd0);
      send_cmd(CMD_TERMINATE, 6'd1, 8'd0);
      send_cmd(CMD_TERMINATE, 6'd4, 8'd0);
      send_cmd(CMD_BLOCK, 6'd3, 8'd0);
      send_cmd(CMD_YIELD, 6'd0, 8'd0);
      send_cmd(CMD_UNBLOCK, 6'd3, 8'd0);
      send_cmd(CMD_YIELD, 6'd0, 8'd0);
      send_cmd(CMD_TERMINATE, 6'd3, 8'd0);
      send_cmd(CMD_BAD_FIRST, TGT_W'($urandom_range(0, 63)), NPRIO_W'($urandom_range(0, 255)));
      send_cmd(CMD_BAD_LAST, TGT_W'($urandom_range(0, 63)), NPRIO_W'($urandom_range(0, 255)));
      send_cmd(CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST)), 6'd63, 8'd255);
      send_cmd(CMD_TERMINATE, 6'd3, 8'd0);
      send_cmd(CMD_UNBLOCK, 6'd2, 8'd0);
      send_cmd(CMD_YIELD, 6'd0, 8'd0);
   endtask

   task automatic random_cmd();
      int                 roll;
      logic [CMD_W-1:0]   c;
      logic [TGT_W-1:0]   t;
      logic [NPRIO_W-1:0] p;
      roll = $urandom_range(0, 99);
      if (roll < 16) c = CMD_CREATE;
      else if (roll < 44) c = CMD_YIELD;
      else if (roll < 66) c = CMD_BLOCK;
      else if (roll < 88) c = CMD_UNBLOCK;
      else if (roll < 94) c = CMD_TERMINATE;
      else c = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
      if ($urandom_range(0, 3) == 0) t = TGT_W'($urandom_range(0, 63));
      else t = sb.pick_target(c == CMD_UNBLOCK && $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) p = NPRIO_W'($urandom_range(0, 3) * 85);
      else p = NPRIO_W'($urandom_range(0, 255));
      send_cmd(c, t, p);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_YIELD;
      req_target_id    = '0;
      req_new_priority = '0;
      idling_on        = 1'b1;
      sb               = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      directed_cmds();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_results();
         if (n == RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
         random_cmd();
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d results never arrived", sb.outstanding()));
      $display("commands: create %0d, yield %0d, block %0d, unblock %0d, terminate %0d, bad %0d",
               sb.cmd_seen[CMD_CREATE], sb.cmd_seen[CMD_YIELD], sb.cmd_seen[CMD_BLOCK],
               sb.cmd_seen[CMD_UNBLOCK], sb.cmd_seen[CMD_TERMINATE],
               sb.cmd_seen[5] + sb.cmd_seen[6] + sb.cmd_seen[7]);
      $display("%0d results checked, %0d switches, %0d table-full creates, %0d mismatches",
               sb.checked, sb.switches, sb.full_hits, sb.errors);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/prqs_pkg.sv
rtl/prqs_ram.sv
rtl/priority_ready_queue_scheduler.sv
rtl/prqs_checker.sv
tb/sched_sb_pkg.sv
tb/tb_top.sv
